### src/u2c_pkg.sv
// u2c_pkg: shared types, constants and the code point to glyph map
// for the UTF-8 to CP1251 text cursor. No dependencies.
`default_nettype none

package u2c_pkg;

   localparam int COORD_W     = 15;
   localparam int DIM_W       = 10;
   localparam int SCALE_W     = 4;
   localparam int CP_W        = 11;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 10;
   localparam int MID_DEPTH   = 2;
   localparam int OUT_DEPTH   = 2;
   localparam int MAP_ENTRIES = 61;

   localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_HEIGHT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_SCALE     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_ENABLE    = 4'd3;

   localparam logic [DIM_W-1:0]   RESET_WIDTH  = 10'd84;
   localparam logic [DIM_W-1:0]   RESET_HEIGHT = 10'd48;
   localparam logic [SCALE_W-1:0] RESET_SCALE  = 4'd1;

   localparam logic [7:0] CODE_LF       = 8'h0A;
   localparam logic [7:0] CODE_CR       = 8'h0D;
   localparam logic [7:0] CODE_UNMAPPED = 8'd127;

   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [SCALE_W-1:0] scale;
      logic               wrap;
   } cfg_type;

   typedef struct packed {
      logic       consumed;
      logic [7:0] code;
   } tok_type;

   typedef struct packed {
      logic               consumed_char;
      logic               draw_request;
      logic [7:0]         glyph_code;
      logic [COORD_W-1:0] glyph_x;
      logic [COORD_W-1:0] glyph_y;
      logic               on_screen;
   } rsp_type;

   localparam logic [15:0] MAP_POINT [MAP_ENTRIES] = '{
      16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021, 16'h20AC, 16'h2030,
      16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F, 16'h0452, 16'h2018,
      16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h2122, 16'h0459,
      16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F, 16'h00A0, 16'h040E, 16'h045E,
      16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7, 16'h0401, 16'h00A9, 16'h0404,
      16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407, 16'h00B0, 16'h00B1, 16'h0406,
      16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116, 16'h0454,
      16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
   };

   localparam logic [7:0] MAP_CODE [MAP_ENTRIES] = '{
      8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
      8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
      8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h99, 8'h9A,
      8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hA0, 8'hA1, 8'hA2,
      8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA,
      8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hB2,
      8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBA,
      8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF
   };

   function automatic logic [7:0] map_point(input logic [CP_W-1:0] cp);
      logic [7:0]  code;
      logic        found;
      logic [CP_W-1:0] diff;
      code  = CODE_UNMAPPED;
      found = 1'b0;
      diff  = '0;
      if (cp >= 11'h410 && cp <= 11'h44F) begin
         diff = cp - 11'h350;
         code = diff[7:0];
      end else if (cp >= 11'h080 && cp <= 11'h0FF) begin
         code = cp[7:0];
      end else if (cp >= 11'h402 && cp <= 11'h403) begin
         diff = cp - 11'h382;
         code = diff[7:0];
      end else begin
         for (int i = 0; i < MAP_ENTRIES; i++) begin
            if (!found && {5'b0, cp} == MAP_POINT[i]) begin
               code  = MAP_CODE[i];
               found = 1'b1;
            end
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

### src/utf8_to_cp1251_text_cursor.sv
// utf8_to_cp1251_text_cursor: top level; configuration registers, front decoder,
// decoded-character queue, cursor back end and result queue.
// Depends on u2c_pkg, u2c_fifo, u2c_front, u2c_back.
//
// Usage: write UTF-8 text bytes on req_in_byte with req_push while req_full is
// low. Every accepted byte yields exactly one result transaction, in order, on
// the rsp_ ports while rsp_empty is low; rsp_pop takes it. Bytes that are held
// as a lead or dropped give a result with rsp_consumed_char low and all other
// fields zero.
// An accepted byte's token is registered in the middle queue and its result
// in the result queue. Throughput: one byte per cycle while the receiver
// keeps up, set by the combinational map lookup in the front end and the
// cursor update in the back end. A two-entry queue sits between front and
// back and another at the output, so input keeps flowing while the receiver
// stalls until both fill; after that req_full rises until rsp_pop resumes.
// Configuration: csr_ready is always high; indexes 0 to 3 select display width,
// display height, text scale and wrap enable, other indexes are ignored.
// Write only while no transaction is in flight.
// Reset: synchronous; clears the queues, the held lead byte and the cursor and
// loads width 84, height 48, scale 1, wrap on.
`default_nettype none

module utf8_to_cp1251_text_cursor #(
   parameter int CELL_WIDTH  = 6,
   parameter int CELL_HEIGHT = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [7:0]                       req_in_byte,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_consumed_char,
   output logic                                  rsp_draw_request,
   output logic [7:0]                            rsp_glyph_code,
   output logic [u2c_pkg::COORD_W-1:0]           rsp_glyph_x,
   output logic [u2c_pkg::COORD_W-1:0]           rsp_glyph_y,
   output logic                                  rsp_on_screen,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [u2c_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [u2c_pkg::CSR_DATA_W-1:0]   csr_data
);
   import u2c_pkg::*;

   cfg_type cfg_ff, cfg_in;
   tok_type front_tok, mid_tok;
   rsp_type back_rsp, out_rsp;
   logic    accept;
   logic    mid_empty, mid_pop;
   logic    out_full, out_push;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DISPLAY_WIDTH:  cfg_in.width  = csr_data[DIM_W-1:0];
            CSR_DISPLAY_HEIGHT: cfg_in.height = csr_data[DIM_W-1:0];
            CSR_TEXT_SCALE:     cfg_in.scale  = csr_data[SCALE_W-1:0];
            CSR_WRAP_ENABLE:    cfg_in.wrap   = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= RESET_WIDTH;
         cfg_ff.height <= RESET_HEIGHT;
         cfg_ff.scale  <= RESET_SCALE;
         cfg_ff.wrap   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   u2c_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .tok     (front_tok)
   );

   u2c_fifo #(
      .WIDTH ($bits(tok_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_tok),
      .full      (req_full),
      .pop       (mid_pop),
      .pop_data  (mid_tok),
      .empty     (mid_empty)
   );

   u2c_back #(
      .CELL_WIDTH  (CELL_WIDTH),
      .CELL_HEIGHT (CELL_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .tok       (mid_tok),
      .tok_valid (!mid_empty),
      .tok_pop   (mid_pop),
      .out_full  (out_full),
      .rsp_push  (out_push),
      .rsp       (back_rsp)
   );

   u2c_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_rsp),
      .empty     (rsp_empty)
   );

   assign rsp_consumed_char = out_rsp.consumed_char;
   assign rsp_draw_request  = out_rsp.draw_request;
   assign rsp_glyph_code    = out_rsp.glyph_code;
   assign rsp_glyph_x       = out_rsp.glyph_x;
   assign rsp_glyph_y       = out_rsp.glyph_y;
   assign rsp_on_screen     = out_rsp.on_screen;

endmodule

`default_nettype wire

### src/u2c_fifo.sv
// u2c_fifo: small show-ahead transaction queue built from registers.
// Uses no package; width and depth are parameters.
`default_nettype none

module u2c_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

### src/u2c_front.sv
// u2c_front: UTF-8 lead byte tracking and code point to glyph mapping.
// Depends on u2c_pkg.
`default_nettype none

module u2c_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     in_byte,
   output u2c_pkg::tok_type    tok
);
   import u2c_pkg::*;

   logic [7:0]      lead_ff, lead_in;
   logic [CP_W-1:0] cp;

   assign cp = {lead_ff[4:0], 6'b0} + {5'b0, in_byte[5:0]};

   always_comb begin
      lead_in      = lead_ff;
      tok.consumed = 1'b1;
      tok.code     = in_byte;
      if (lead_ff == '0 && in_byte[7]) begin
         tok.consumed = 1'b0;
         tok.code     = '0;
         if (!in_byte[5]) begin
            lead_in = in_byte;
         end
      end else begin
         lead_in = '0;
         if (lead_ff != '0) begin
            tok.code = map_point(cp);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
      end else if (accept) begin
         lead_ff <= lead_in;
      end
   end

   a_lead_form: assert property (@(posedge clock) disable iff (reset)
      (lead_ff != '0) |-> (lead_ff[7] && !lead_ff[5]))
      else $error("held lead byte malformed");

endmodule

`default_nettype wire

### src/u2c_back.sv
// u2c_back: text cursor; turns decoded characters into draw transactions.
// Depends on u2c_pkg.
`default_nettype none

module u2c_back #(
   parameter int CELL_WIDTH  = 6,
   parameter int CELL_HEIGHT = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire u2c_pkg::cfg_type cfg,
   input  wire u2c_pkg::tok_type tok,
   input  wire logic          tok_valid,
   output logic               tok_pop,
   input  wire logic          out_full,
   output logic               rsp_push,
   output u2c_pkg::rsp_type   rsp
);
   import u2c_pkg::*;

   localparam int SCALE_MAX = (1 << SCALE_W) - 1;
   localparam int STEP_X_W  = $clog2(SCALE_MAX * CELL_WIDTH + 1);
   localparam int STEP_Y_W  = $clog2(SCALE_MAX * CELL_HEIGHT + 1);

   function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W:0]   b);
      logic [COORD_W:0] sum;
      sum = {1'b0, a} + b;
      return sum[COORD_W] ? COORD_MAX : sum[COORD_W-1:0];
   endfunction

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [STEP_X_W-1:0] step_x;
   logic [STEP_Y_W-1:0] step_y;
   logic [COORD_W:0]    step_x_ext, step_y_ext;
   logic [COORD_W-1:0]  col_step, row_step;
   logic                wrap_hit, go;

   assign step_x     = STEP_X_W'(cfg.scale) * STEP_X_W'(CELL_WIDTH);
   assign step_y     = STEP_Y_W'(cfg.scale) * STEP_Y_W'(CELL_HEIGHT);
   assign step_x_ext = (COORD_W + 1)'(step_x);
   assign step_y_ext = (COORD_W + 1)'(step_y);
   assign col_step   = sat_add(col_ff, step_x_ext);
   assign row_step   = sat_add(row_ff, step_y_ext);
   assign wrap_hit   = cfg.wrap &&
                       (({1'b0, col_step} + step_x_ext) > (COORD_W + 1)'(cfg.width));

   assign go       = tok_valid && !out_full;
   assign tok_pop  = go;
   assign rsp_push = go;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      rsp    = '0;
      if (tok.consumed) begin
         rsp.consumed_char = 1'b1;
         priority if (tok.code == CODE_LF) begin
            row_in = row_step;
            col_in = '0;
         end else if (tok.code == CODE_CR) begin
            col_in = col_ff;
         end else begin
            rsp.draw_request = 1'b1;
            rsp.glyph_code   = tok.code;
            rsp.glyph_x      = col_ff;
            rsp.glyph_y      = row_ff;
            rsp.on_screen    = (col_ff < COORD_W'(cfg.width)) &&
                               (row_ff < COORD_W'(cfg.height));
            col_in = col_step;
            if (wrap_hit) begin
               row_in = row_step;
               col_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (go) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   a_newline_col: assert property (@(posedge clock) disable iff (reset)
      (go && tok.consumed && tok.code == CODE_LF) |=> (col_ff == '0))
      else $error("newline left column nonzero");

   a_draw_consumed: assert property (@(posedge clock) disable iff (reset)
      (go && rsp.draw_request) |-> rsp.consumed_char)
      else $error("draw without consumed character");

   a_row_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (row_ff >= $past(row_ff)))
      else $error("cursor row moved up");

endmodule

`default_nettype wire
